// ----- design/gesture_edit_queue_with_change_drop_top_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the gesture edit queue
// Concurrent assertion wrappers; they compile to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef GESTURE_EDIT_QUEUE_WITH_CHANGE_DROP_TOP_MACROS_SVH
`define GESTURE_EDIT_QUEUE_WITH_CHANGE_DROP_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Checked on every rising edge, suspended while reset is asserted.
`define GEQ_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("GEQ assertion failed");

// Checked on every rising edge, reset included.
`define GEQ_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("GEQ assertion failed");

`else

`define GEQ_ASSERT(lbl, clk, rstn, prop)
`define GEQ_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// ----- design/geq_pkg.sv -----
// ----------------------------------------------------------------------------
// geq_pkg
// Types, codes and controller/datapath interface for the gesture edit queue.
// ----------------------------------------------------------------------------
package geq_pkg;

  localparam int QUEUE_DEPTH_DEF = 64;

  localparam int ID_W    = 32;
  localparam int PHASE_W = 2;
  localparam int VALUE_W = 17;

  localparam logic [VALUE_W-1:0] VALUE_ONE = 17'h10000;

  localparam logic [PHASE_W-1:0] PHASE_BEGIN  = 2'd0;
  localparam logic [PHASE_W-1:0] PHASE_CHANGE = 2'd1;
  localparam logic [PHASE_W-1:0] PHASE_END    = 2'd2;

  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_DRAIN  = 1'b1;

  typedef struct packed {
    logic               opcode;
    logic [ID_W-1:0]    param_id;
    logic [PHASE_W-1:0] phase;
    logic [VALUE_W-1:0] edit_value;
  } in_item_t;

  typedef struct packed {
    logic               entry_valid;
    logic [ID_W-1:0]    out_param_id;
    logic [PHASE_W-1:0] out_phase;
    logic [VALUE_W-1:0] out_value;
    logic               last;
  } out_item_t;

  // One stored edit: 51 bits.
  typedef struct packed {
    logic [ID_W-1:0]    param_id;
    logic [PHASE_W-1:0] phase;
    logic [VALUE_W-1:0] value;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;       // capture the incoming item
    logic shift_start;  // set up the close-up walk of a full queue
    logic rd;           // read the entry at the walk index
    logic shift_step;   // move the entry just read down by one if past the victim
    logic append;       // write the held edit at the back
    logic drain_start;  // set the walk index to the front
    logic drain_emit;   // load the entry just read into the output register
    logic empty_emit;   // load the empty-drain result
  } geq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_drain;      // incoming item is a drain
    logic in_bad_phase;  // incoming record has an undefined phase
    logic cnt_zero;      // queue is empty
    logic cnt_full;      // queue holds its full depth
    logic idx_last;      // walk index sits on the last queued entry
    logic out_free;      // output register can take a result this cycle
  } geq_status_t;

endpackage

// ----- design/geq_ctrl.sv -----
// ----------------------------------------------------------------------------
// geq_ctrl
// Sequencer for recording, close-up of a full queue and draining.
// ----------------------------------------------------------------------------
module geq_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  geq_pkg::geq_status_t sts,
  output geq_pkg::geq_cmd_t    cmd
);
  import geq_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE      = 7'b0000001,
    S_SHIFT_RD  = 7'b0000010,
    S_SHIFT_WR  = 7'b0000100,
    S_APPEND    = 7'b0001000,
    S_DRAIN_RD  = 7'b0010000,
    S_DRAIN_OUT = 7'b0100000,
    S_EMPTY_OUT = 7'b1000000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (sts.in_drain) begin
            if (sts.cnt_zero) begin
              state_nxt = S_EMPTY_OUT;
            end else begin
              cmd.drain_start = 1'b1;
              state_nxt       = S_DRAIN_RD;
            end
          end else if (!sts.in_bad_phase) begin
            if (sts.cnt_full) begin
              cmd.shift_start = 1'b1;
              state_nxt       = S_SHIFT_RD;
            end else begin
              state_nxt = S_APPEND;
            end
          end
        end
      end
      S_SHIFT_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        cmd.shift_step = 1'b1;
        state_nxt      = sts.idx_last ? S_APPEND : S_SHIFT_RD;
      end
      S_APPEND: begin
        cmd.append = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_DRAIN_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_DRAIN_OUT;
      end
      S_DRAIN_OUT: begin
        if (sts.out_free) begin
          cmd.drain_emit = 1'b1;
          state_nxt      = sts.idx_last ? S_IDLE : S_DRAIN_RD;
        end
      end
      S_EMPTY_OUT: begin
        if (sts.out_free) begin
          cmd.empty_emit = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- design/geq_dp.sv -----
// ----------------------------------------------------------------------------
// geq_dp
// Entry memory, counters, walk index and output register of the edit queue.
// ----------------------------------------------------------------------------
`include "gesture_edit_queue_with_change_drop_top_macros.svh"

module geq_dp #(
  parameter int QUEUE_DEPTH = geq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  geq_pkg::in_item_t    in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output geq_pkg::out_item_t   out_data,
  input  geq_pkg::geq_cmd_t    cmd,
  output geq_pkg::geq_status_t sts
);
  import geq_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  entry_t mem [QUEUE_DEPTH];

  logic [CW-1:0] count_r;
  logic [CW-1:0] chg_cnt_r;
  logic [AW-1:0] idx_r;
  logic          found_r;
  entry_t        in_r;
  entry_t        rdata_r;
  logic          out_valid_r;
  out_item_t     out_r;

  logic [VALUE_W-1:0] sat_value;
  logic               we;
  logic [AW-1:0]      waddr;
  entry_t             wdata;
  logic               rd_change;

  // Incoming edit, conditioned: only a change keeps its value, capped at one.
  always_comb begin
    if (in_data.phase == PHASE_CHANGE) begin
      sat_value = (in_data.edit_value > VALUE_ONE) ? VALUE_ONE : in_data.edit_value;
    end else begin
      sat_value = '0;
    end
  end

  assign rd_change = (rdata_r.phase == PHASE_CHANGE);

  assign sts.in_drain     = (in_data.opcode == OP_DRAIN);
  assign sts.in_bad_phase = (in_data.phase != PHASE_BEGIN) &&
                            (in_data.phase != PHASE_CHANGE) &&
                            (in_data.phase != PHASE_END);
  assign sts.cnt_zero     = (count_r == '0);
  assign sts.cnt_full     = (count_r == CW'(QUEUE_DEPTH));
  assign sts.idx_last     = (CW'(idx_r) == (count_r - CW'(1)));
  assign sts.out_free     = !out_valid_r || !out_stall;

  // Single write port: close-up moves go one slot down, appends go to the back.
  always_comb begin
    we    = 1'b0;
    waddr = count_r[AW-1:0];
    wdata = in_r;
    if (cmd.shift_step && found_r) begin
      we    = 1'b1;
      waddr = idx_r - AW'(1);
      wdata = rdata_r;
    end else if (cmd.append) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rdata_r <= mem[idx_r];
    end
  end

  // Walk index, victim flag and held edit.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      in_r.param_id <= in_data.param_id;
      in_r.phase    <= in_data.phase;
      in_r.value    <= sat_value;
    end
    if (cmd.shift_start) begin
      // With no change entry queued the front entry is the one dropped.
      found_r <= (chg_cnt_r == '0);
      idx_r   <= (chg_cnt_r == '0) ? AW'(1) : '0;
    end else if (cmd.drain_start) begin
      idx_r <= '0;
    end else if (cmd.shift_step) begin
      if (!found_r && rd_change) begin
        found_r <= 1'b1;
      end
      if (!sts.idx_last) begin
        idx_r <= idx_r + AW'(1);
      end
    end else if (cmd.drain_emit && !sts.idx_last) begin
      idx_r <= idx_r + AW'(1);
    end
  end

  // Occupancy and number of queued change entries.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      chg_cnt_r <= '0;
    end else if (cmd.drain_emit && sts.idx_last) begin
      count_r   <= '0;
      chg_cnt_r <= '0;
    end else if (cmd.append) begin
      count_r <= count_r + CW'(1);
      if (in_r.phase == PHASE_CHANGE) begin
        chg_cnt_r <= chg_cnt_r + CW'(1);
      end
    end else if (cmd.shift_step) begin
      if (sts.idx_last) begin
        count_r <= count_r - CW'(1);
      end
      if (!found_r && rd_change) begin
        chg_cnt_r <= chg_cnt_r - CW'(1);
      end
    end
  end

  // Output register: holds a result until the transfer completes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.drain_emit || cmd.empty_emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.drain_emit) begin
      out_r.entry_valid  <= 1'b1;
      out_r.out_param_id <= rdata_r.param_id;
      out_r.out_phase    <= rdata_r.phase;
      out_r.out_value    <= rdata_r.value;
      out_r.last         <= sts.idx_last;
    end else if (cmd.empty_emit) begin
      out_r.entry_valid  <= 1'b0;
      out_r.out_param_id <= '0;
      out_r.out_phase    <= '0;
      out_r.out_value    <= '0;
      out_r.last         <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `GEQ_ASSERT(a_count_bound, clk, rst_n, count_r <= CW'(QUEUE_DEPTH))
  `GEQ_ASSERT(a_chg_within_count, clk, rst_n, chg_cnt_r <= count_r)
  `GEQ_ASSERT(a_append_has_room, clk, rst_n, cmd.append |-> (count_r < CW'(QUEUE_DEPTH)))
  `GEQ_ASSERT(a_last_empties, clk, rst_n, (cmd.drain_emit && sts.idx_last) |=> (count_r == '0))
  `GEQ_ASSERT(a_emit_needs_room, clk, rst_n, (cmd.drain_emit || cmd.empty_emit) |-> sts.out_free)

endmodule

// ----- design/gesture_edit_queue_with_change_drop_top.sv -----
// ----------------------------------------------------------------------------
// gesture_edit_queue_with_change_drop_top
// Bounded queue of parameter edits that drops the oldest change on overflow.
//
// Each input transfer either records one edit (parameter id, gesture phase and
// Q1.16 value) or drains the queue. Begin and end edits are stored with value
// zero, a change value above 1.0 is capped at 65536, and a record with the
// undefined phase code is taken and ignored. When a record meets a full queue,
// the oldest change entry is removed and the entries behind it close up; with
// no change entry queued, the front entry goes instead. A drain produces one
// output transfer per queued entry, oldest first, with last set on the final
// one, and leaves the queue empty; a drain of an empty queue produces a single
// transfer with entry_valid low and last high. Records produce no output.
// The close-up walks the single-port entry memory with a read and a write per
// entry before the held edit is appended, and a drain does one memory read and
// one output load per entry, waiting whenever the output side stalls.
// Input stall is high while an item is in progress. Output transfers leave
// from a register, so a new record can be taken while the last drained
// result is still waiting to be accepted downstream.
// ----------------------------------------------------------------------------
module gesture_edit_queue_with_change_drop_top #(
  parameter int QUEUE_DEPTH = geq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  geq_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output geq_pkg::out_item_t out_data
);
  import geq_pkg::*;

  // The controller only sequences; all storage and arithmetic sit in the
  // datapath, and the two talk through the command and status structs.
  geq_cmd_t    cmd;
  geq_status_t sts;

  geq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  geq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
